// File: rtl/ascon_pkg.sv
`timescale 1ns / 1ps
// types, codes and round function shared by the ascon engine modules
// no dependencies

package ascon_pkg;

  localparam int unsigned LaneW    = 64;
  localparam int unsigned NumLanes = 5;

  typedef logic [NumLanes-1:0][LaneW-1:0] lanes_t;

  // initial value of lane 0 on start
  localparam logic [LaneW-1:0] AsconIv = 64'h80400c0600000000;

  // round counter runs up to the last index of the full permutation
  localparam logic [3:0] RoundFirstFull  = 4'd0;
  localparam logic [3:0] RoundFirstBlock = 4'd4;
  localparam logic [3:0] RoundLast       = 4'd11;

  // item kind codes
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_BLOCK  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // result kind codes
  localparam logic RES_CIPHER = 1'b0;
  localparam logic RES_TAG    = 1'b1;

  // configuration register indexes
  localparam logic CFG_KEY_FIRST  = 1'b0;
  localparam logic CFG_KEY_SECOND = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_ROUND
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_BLOCK,
    MODE_FINISH
  } run_mode_e;

  // controller to datapath commands
  typedef struct packed {
    logic       load_start;
    logic       absorb;
    logic       key_mix;
    logic       round_en;
    logic [3:0] round_idx;
    logic       last_start;
    logic       last_finish;
  } ascon_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_blocked;
  } ascon_stat_t;

  // round constant 0xf0 - 0x0f * k
  function automatic logic [7:0] round_const(logic [3:0] k);
    logic [7:0] kk;
    kk = {4'b0, k};
    return 8'hF0 - ((kk << 4) - kk);
  endfunction

  function automatic logic [LaneW-1:0] rotr(logic [LaneW-1:0] v, int unsigned n);
    return (v >> n) | (v << (LaneW - n));
  endfunction

  // one permutation round: constant, bitsliced sbox, linear layer
  function automatic lanes_t ascon_round(lanes_t a_in, logic [7:0] c);
    lanes_t a;
    lanes_t b;
    a = a_in;
    a[2] = a[2] ^ {56'b0, c};
    a[0] = a[0] ^ a[4];
    a[4] = a[4] ^ a[3];
    a[2] = a[2] ^ a[1];
    b = a;
    a[0] = b[0] ^ (~b[1] & b[2]);
    a[1] = b[1] ^ (~b[2] & b[3]);
    a[2] = b[2] ^ (~b[3] & b[4]);
    a[3] = b[3] ^ (~b[4] & b[0]);
    a[4] = b[4] ^ (~b[0] & b[1]);
    a[1] = a[1] ^ a[0];
    a[0] = a[0] ^ a[4];
    a[3] = a[3] ^ a[2];
    a[2] = ~a[2];
    a[0] = a[0] ^ rotr(a[0], 19) ^ rotr(a[0], 28);
    a[1] = a[1] ^ rotr(a[1], 61) ^ rotr(a[1], 39);
    a[2] = a[2] ^ rotr(a[2], 1) ^ rotr(a[2], 6);
    a[3] = a[3] ^ rotr(a[3], 10) ^ rotr(a[3], 17);
    a[4] = a[4] ^ rotr(a[4], 7) ^ rotr(a[4], 41);
    return a;
  endfunction

endpackage

// File: rtl/ascon_ctrl.sv
`timescale 1ns / 1ps
// controller: accepts items and sequences the permutation rounds
// depends on ascon_pkg

module ascon_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  ascon_pkg::ascon_stat_t stat_i,
  output ascon_pkg::ascon_cmd_t  cmd_o
);
  import ascon_pkg::*;

  ctrl_state_e state_q, state_d;
  run_mode_e   mode_q, mode_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        accept;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_START;
      cnt_q   <= RoundFirstFull;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
    end
  end

  // hold off while rounds run or the result slot cannot drain
  assign in_stall_o = (state_q != ST_IDLE) || stat_i.out_blocked;
  assign accept     = in_valid_i && !in_stall_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_START: begin
              cmd_o.load_start = 1'b1;
              mode_d  = MODE_START;
              cnt_d   = RoundFirstFull;
              state_d = ST_ROUND;
            end
            KIND_BLOCK: begin
              cmd_o.absorb = 1'b1;
              mode_d  = MODE_BLOCK;
              cnt_d   = RoundFirstBlock;
              state_d = ST_ROUND;
            end
            KIND_FINISH: begin
              cmd_o.key_mix = 1'b1;
              mode_d  = MODE_FINISH;
              cnt_d   = RoundFirstFull;
              state_d = ST_ROUND;
            end
            default: begin
              // unused kind is dropped
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ROUND: begin
        cmd_o.round_en  = 1'b1;
        cmd_o.round_idx = cnt_q;
        if (cnt_q == RoundLast) begin
          cmd_o.last_start  = (mode_q == MODE_START);
          cmd_o.last_finish = (mode_q == MODE_FINISH);
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ascon_dp.sv
`timescale 1ns / 1ps
// datapath: key registers, state lanes, round unit and result register
// depends on ascon_pkg

module ascon_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [63:0]            cfg_data_i,
  input  logic [63:0]            word_first_i,
  input  logic [63:0]            word_second_i,
  input  ascon_pkg::ascon_cmd_t  cmd_i,
  output ascon_pkg::ascon_stat_t stat_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   result_kind_o,
  output logic [63:0]            out_first_o,
  output logic [63:0]            out_second_o
);
  import ascon_pkg::*;

  logic [LaneW-1:0] key_first_q, key_second_q;
  lanes_t           lanes_q, lanes_d;
  lanes_t           round_out;
  logic             out_valid_q, out_valid_d;
  logic             res_kind_q, res_kind_d;
  logic [LaneW-1:0] out_first_q, out_first_d;
  logic [LaneW-1:0] out_second_q, out_second_d;
  logic [LaneW-1:0] abs0, abs1;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= '0;
      key_second_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_KEY_FIRST) begin
        key_first_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_KEY_SECOND) begin
        key_second_q <= cfg_data_i;
      end
    end
  end

  // round unit, one round per cycle
  assign round_out = ascon_round(lanes_q, round_const(cmd_i.round_idx));

  assign abs0 = lanes_q[0] ^ word_first_i;
  assign abs1 = lanes_q[1] ^ word_second_i;

  // lane update
  always_comb begin
    lanes_d = lanes_q;
    if (cmd_i.load_start) begin
      lanes_d[0] = AsconIv;
      lanes_d[1] = key_first_q;
      lanes_d[2] = key_second_q;
      lanes_d[3] = word_first_i;
      lanes_d[4] = word_second_i;
    end else if (cmd_i.absorb) begin
      lanes_d[0] = abs0;
      lanes_d[1] = abs1;
    end else if (cmd_i.key_mix) begin
      lanes_d[1] = lanes_q[1] ^ key_first_q;
      lanes_d[2] = lanes_q[2] ^ key_second_q;
    end else if (cmd_i.round_en) begin
      lanes_d = round_out;
      if (cmd_i.last_start) begin
        lanes_d[3] = round_out[3] ^ key_first_q;
        lanes_d[4] = round_out[4] ^ key_second_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= '0;
    end else begin
      lanes_q <= lanes_d;
    end
  end

  // result register, drains independently of the rounds
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    res_kind_d   = res_kind_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    if (cmd_i.absorb) begin
      out_valid_d  = 1'b1;
      res_kind_d   = RES_CIPHER;
      out_first_d  = abs0;
      out_second_d = abs1;
    end else if (cmd_i.last_finish) begin
      out_valid_d  = 1'b1;
      res_kind_d   = RES_TAG;
      out_first_d  = round_out[3] ^ key_first_q;
      out_second_d = round_out[4] ^ key_second_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q   <= res_kind_d;
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
  end

  assign stat_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = res_kind_q;
  assign out_first_o        = out_first_q;
  assign out_second_o       = out_second_q;

endmodule

// File: rtl/ascon_aead_encrypt_engine_unit.sv
`timescale 1ns / 1ps
// top level of the ascon encryption engine: controller plus datapath
// depends on ascon_pkg, ascon_ctrl, ascon_dp

// Ascon-128 style encryption without associated data or padding. Load the key
// through the write port (index 0 first word, 1 second word) while idle. A
// start item (kind 0) takes the nonce and runs 12 rounds with no result; a
// block item (kind 1) returns its ciphertext in the cycle after acceptance and
// then runs 8 rounds; a finish item (kind 2) runs 12 rounds and returns the
// tag. The round unit does one permutation round per clock, so a new item is
// taken only once the rounds of the previous item are done. A waiting result
// does not block the rounds; an item that arrives while the result register
// is still full and stalled is also held off.

module ascon_aead_encrypt_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] word_first_i,
  input  logic [63:0] word_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [63:0] out_first_o,
  output logic [63:0] out_second_o
);
  import ascon_pkg::*;

  ascon_cmd_t  cmd;
  ascon_stat_t stat;

  // item sequencing
  ascon_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // state lanes and result
  ascon_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .word_first_i  (word_first_i),
    .word_second_i (word_second_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .out_first_o   (out_first_o),
    .out_second_o  (out_second_o)
  );

endmodule

// File: rtl/ascon_chk.sv
`timescale 1ns / 1ps
// port-level checker for the ascon engine, bound to the top level
// depends on ascon_pkg

module ascon_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  kind_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o
);
  import ascon_pkg::*;

  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a block item gives its ciphertext right away
  a_block_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && kind_i == KIND_BLOCK |=> out_valid_o && result_kind_o == RES_CIPHER)
    else $error("ciphertext missing after block item");

  // the engine is busy after a real item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (kind_i == KIND_START || kind_i == KIND_BLOCK || kind_i == KIND_FINISH)
    |=> in_stall_o)
    else $error("item taken while rounds run");

  // the tag shows up in the cycle after the twelfth round
  a_tag_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && kind_i == KIND_FINISH |-> ##13 out_valid_o && result_kind_o == RES_TAG)
    else $error("tag not delivered on time");

  // nothing is shown while the finish rounds start
  a_finish_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && kind_i == KIND_FINISH |=> !out_valid_o)
    else $error("unexpected result after finish item");

endmodule

bind ascon_aead_encrypt_engine_unit ascon_chk u_chk (.*);

// File: tb/ascon_engine_checker.sv
`timescale 1ns / 1ps
// checker for the ascon encryption engine: predicts each result and compares it
// depends on ascon_pkg

module ascon_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [63:0] word_first_i,
  input  logic [63:0] word_second_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        result_kind_i,
  input  logic [63:0] out_first_i,
  input  logic [63:0] out_second_i,
  output int          mismatches_o,
  output int          owed_o
);
  import ascon_pkg::*;

  localparam int unsigned FullRounds  = 12;
  localparam int unsigned BlockRounds = 8;

  typedef struct packed {
    logic        res_kind;
    logic [63:0] first;
    logic [63:0] second;
  } engine_out_t;

  // model copy of the sponge state and key
  lanes_t      lanes_q;
  logic [63:0] key_first_q;
  logic [63:0] key_second_q;
  engine_out_t owed_q[$];

  function automatic logic [63:0] ror64(logic [63:0] v, int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // constant add, bitsliced sbox with lane 2 inverted, linear diffusion
  function automatic lanes_t sponge_round(lanes_t s, logic [63:0] rc);
    lanes_t t;
    s[2] = s[2] ^ rc;
    s[0] = s[0] ^ s[4];
    s[4] = s[4] ^ s[3];
    s[2] = s[2] ^ s[1];
    for (int j = 0; j < 5; j++) begin
      t[j] = s[j] ^ (~s[(j + 1) % 5] & s[(j + 2) % 5]);
    end
    t[1] = t[1] ^ t[0];
    t[0] = t[0] ^ t[4];
    t[3] = t[3] ^ t[2];
    t[2] = ~t[2];
    t[0] = t[0] ^ ror64(t[0], 19) ^ ror64(t[0], 28);
    t[1] = t[1] ^ ror64(t[1], 61) ^ ror64(t[1], 39);
    t[2] = t[2] ^ ror64(t[2], 1) ^ ror64(t[2], 6);
    t[3] = t[3] ^ ror64(t[3], 10) ^ ror64(t[3], 17);
    t[4] = t[4] ^ ror64(t[4], 7) ^ ror64(t[4], 41);
    return t;
  endfunction

  // short permutations use the tail of the constant schedule
  function automatic lanes_t sponge_permute(lanes_t s, int unsigned nr);
    logic [63:0] rc;
    for (int unsigned i = 0; i < nr; i++) begin
      rc = 64'hf0 - 64'h0f * 64'(FullRounds - nr + i);
      s = sponge_round(s, rc);
    end
    return s;
  endfunction

  // advance the state by one item and queue the result it owes
  task automatic absorb_item(logic [1:0] k, logic [63:0] w0, logic [63:0] w1);
    engine_out_t res;
    case (k)
      KIND_START: begin
        lanes_q[0] = AsconIv;
        lanes_q[1] = key_first_q;
        lanes_q[2] = key_second_q;
        lanes_q[3] = w0;
        lanes_q[4] = w1;
        lanes_q = sponge_permute(lanes_q, FullRounds);
        lanes_q[3] = lanes_q[3] ^ key_first_q;
        lanes_q[4] = lanes_q[4] ^ key_second_q;
      end
      KIND_BLOCK: begin
        lanes_q[0] = lanes_q[0] ^ w0;
        lanes_q[1] = lanes_q[1] ^ w1;
        res.res_kind = RES_CIPHER;
        res.first    = lanes_q[0];
        res.second   = lanes_q[1];
        owed_q.push_back(res);
        lanes_q = sponge_permute(lanes_q, BlockRounds);
      end
      KIND_FINISH: begin
        lanes_q[1] = lanes_q[1] ^ key_first_q;
        lanes_q[2] = lanes_q[2] ^ key_second_q;
        lanes_q = sponge_permute(lanes_q, FullRounds);
        res.res_kind = RES_TAG;
        res.first    = lanes_q[3] ^ key_first_q;
        res.second   = lanes_q[4] ^ key_second_q;
        owed_q.push_back(res);
      end
      default: ;  // unused kind leaves everything alone
    endcase
  endtask

  // watch both channels and the key port at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    engine_out_t want;
    if (!rst_ni) begin
      lanes_q      = '0;
      key_first_q  = '0;
      key_second_q = '0;
      owed_q.delete();
      mismatches_o = 0;
      owed_o       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_KEY_FIRST:  key_first_q  = cfg_data_i;
          CFG_KEY_SECOND: key_second_q = cfg_data_i;
          default: ;
        endcase
      end
      // a result leaving now belongs to an earlier item
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          $error("result with nothing owed: kind %0d, %h %h",
                 result_kind_i, out_first_i, out_second_i);
          mismatches_o++;
        end else begin
          want = owed_q.pop_front();
          if (result_kind_i !== want.res_kind) begin
            $error("result_kind: expected %0d, got %0d", want.res_kind, result_kind_i);
            mismatches_o++;
          end
          if (out_first_i !== want.first) begin
            $error("out_first: expected %h, got %h", want.first, out_first_i);
            mismatches_o++;
          end
          if (out_second_i !== want.second) begin
            $error("out_second: expected %h, got %h", want.second, out_second_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_item(kind_i, word_first_i, word_second_i);
      end
      owed_o = owed_q.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench top for the ascon encryption engine: stimulus, stalls and verdict
// depends on ascon_pkg, ascon_aead_encrypt_engine_unit, ascon_engine_checker

module tb;
  import ascon_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RandomItems  = 750;
  localparam int         DrainCycles  = 20;
  localparam int         WatchdogLimit = 2000;
  localparam logic [63:0] AllOnes     = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_KEY_FIRST;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = KIND_START;
  logic [63:0] word_first_i = '0;
  logic [63:0] word_second_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [63:0] out_first_o;
  logic [63:0] out_second_o;

  int mismatches;
  int owed;
  int calm_items = 0;
  int stall_left = 0;
  int free_left = 0;
  int idle_cycles = 0;

  ascon_aead_encrypt_engine_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .word_first_i  (word_first_i),
    .word_second_i (word_second_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .out_first_o   (out_first_o),
    .out_second_o  (out_second_o)
  );

  ascon_engine_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .kind_i        (kind_i),
    .word_first_i  (word_first_i),
    .word_second_i (word_second_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_i (result_kind_o),
    .out_first_i   (out_first_o),
    .out_second_i  (out_second_o),
    .mismatches_o  (mismatches),
    .owed_o        (owed)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver stalls: short bursts, a few long ones, and stall-free stretches
  always @(negedge clk_i) begin
    int r;
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (free_left > 0) begin
        free_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) free_left = $urandom_range(20, 80);
        else if (r < 40) stall_left = $urandom_range(1, 3);
        else if (r < 45) stall_left = $urandom_range(10, 40);
      end
    end
  end

  // hang detection: cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("** ascon_aead_encrypt_engine_unit: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return AllOnes;
    return {$urandom, $urandom};
  endfunction

  // drive one item, with a random gap ahead of it, and wait until taken
  task automatic push_item(logic [1:0] k, logic [63:0] w0, logic [63:0] w1);
    int n;
    int r;
    n = 0;
    if (calm_items > 0) begin
      calm_items--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) calm_items = $urandom_range(10, 40);
      else if (r < 55) n = 0;
      else if (r < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
    end
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    word_first_i  <= w0;
    word_second_i <= w1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // wait until every owed result is out and the rounds have finished
  task automatic settle();
    in_valid_i <= 1'b0;
    while (owed != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_keys(logic [63:0] k0, logic [63:0] k1);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_KEY_FIRST;
    cfg_data_i  <= k0;
    @(negedge clk_i);
    cfg_index_i <= CFG_KEY_SECOND;
    cfg_data_i  <= k1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int sent;
    int nblk;
    logic [1:0] k;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero key and zero state straight out of reset, no start
    push_item(KIND_BLOCK, '0, '0);
    push_item(KIND_FINISH, AllOnes, AllOnes);
    push_item(KIND_UNUSED, AllOnes, AllOnes);
    push_item(KIND_BLOCK, AllOnes, AllOnes);

    // all-ones key; finish twice, block after finish
    set_keys(AllOnes, AllOnes);
    push_item(KIND_START, '0, '0);
    push_item(KIND_BLOCK, AllOnes, '0);
    push_item(KIND_BLOCK, '0, AllOnes);
    push_item(KIND_FINISH, '0, '0);
    push_item(KIND_FINISH, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    push_item(KIND_BLOCK, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);

    // back-to-back starts, unused kind inside a message
    set_keys(64'h0123456789abcdef, 64'hfedcba9876543210);
    push_item(KIND_START, AllOnes, AllOnes);
    push_item(KIND_START, rand_word(), rand_word());
    push_item(KIND_UNUSED, rand_word(), rand_word());
    push_item(KIND_BLOCK, rand_word(), rand_word());
    push_item(KIND_FINISH, rand_word(), rand_word());

    // key swapped in the middle of a message
    push_item(KIND_START, rand_word(), rand_word());
    set_keys('0, '0);
    push_item(KIND_BLOCK, rand_word(), rand_word());
    push_item(KIND_FINISH, '0, '0);

    // random messages, mostly well formed, some loose items
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 5) == 0) set_keys(rand_word(), rand_word());
      if ($urandom_range(0, 9) != 0) begin
        push_item(KIND_START, rand_word(), rand_word());
        nblk = $urandom_range(0, 6);
        repeat (nblk) push_item(KIND_BLOCK, rand_word(), rand_word());
        push_item(KIND_FINISH, rand_word(), rand_word());
        sent += nblk + 2;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          k = 2'($urandom_range(0, 3));
          push_item(k, rand_word(), rand_word());
          if (k != KIND_UNUSED) sent++;
        end
      end
    end

    settle();
    if (mismatches == 0 && owed == 0) begin
      $display("** ascon_aead_encrypt_engine_unit: PASSED **");
    end else begin
      $display("** ascon_aead_encrypt_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
